// ----- sv/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivider package
// Shared types, constants and the child vertex emission order.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int COORD_W       = 16;
    localparam int FRAC_DEFAULT  = 14;
    localparam int VERTS_PER_TRI = 12;
    localparam int NUM_VERTS     = 6;
    localparam int NUM_LANES     = 3;

    localparam logic [2:0] V_A   = 3'd0;
    localparam logic [2:0] V_B   = 3'd1;
    localparam logic [2:0] V_C   = 3'd2;
    localparam logic [2:0] V_M12 = 3'd3;
    localparam logic [2:0] V_M23 = 3'd4;
    localparam logic [2:0] V_M31 = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vec;

    typedef struct packed {
        logic deg;
        t_vec pos;
    } t_vert;

    function automatic logic [2:0] emit_sel(input logic [3:0] k);
        logic [2:0] sel;
        case (k)
            4'd0:    sel = V_A;
            4'd1:    sel = V_M12;
            4'd2:    sel = V_M31;
            4'd3:    sel = V_M12;
            4'd4:    sel = V_B;
            4'd5:    sel = V_M23;
            4'd6:    sel = V_M31;
            4'd7:    sel = V_M23;
            4'd8:    sel = V_C;
            4'd9:    sel = V_M31;
            4'd10:   sel = V_M12;
            4'd11:   sel = V_M23;
            default: sel = V_A;
        endcase
        return sel;
    endfunction

endpackage

// ----- sv/stl_div.sv -----
// ----------------------------------------------------------------------------
// Normalizing divider
// Restoring divider giving one rounded, saturated unit vector component.
// ----------------------------------------------------------------------------
module stl_div #(
    parameter int FRAC_BITS = stl_pkg::FRAC_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_ready,
    input  logic [16:0]                       i_m,
    input  logic [30:0]                       i_len,
    input  logic                              i_neg,
    output logic                              o_valid,
    input  logic                              i_take,
    output logic signed [stl_pkg::COORD_W-1:0] o_val
);

    localparam int NUM_W = FRAC_BITS + 32;
    localparam int DW    = (NUM_W > 49) ? NUM_W : 49;
    localparam int SH    = FRAC_BITS + 14;
    localparam logic [3:0] LAST = 4'd9;

    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [16:0]   r_m;
    logic [30:0]   r_len;
    logic          r_neg;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dsh;
    logic [17:0]   r_q;
    logic          r_ovf;

    logic [DW-1:0] num;
    logic [DW-1:0] n_rem;
    logic [DW-1:0] n_dsh;
    logic [17:0]   n_q;
    logic [17:0]   cap;
    logic [17:0]   mag;

    assign o_ready = !r_busy && (!r_done || i_take);
    assign o_valid = r_done;
    assign num     = (DW'(r_m) << SH) + DW'(r_len >> 1);

    always_comb begin
        n_rem = r_rem;
        n_dsh = r_dsh;
        n_q   = r_q;
        for (int j = 0; j < 2; j++) begin
            if (n_rem >= n_dsh) begin
                n_rem = n_rem - n_dsh;
                n_q   = {n_q[16:0], 1'b1};
            end else begin
                n_q   = {n_q[16:0], 1'b0};
            end
            n_dsh = n_dsh >> 1;
        end
    end

    always_comb begin
        cap = r_neg ? 18'd32768 : 18'd32767;
        mag = (r_ovf || (r_q > cap)) ? cap : r_q;
        o_val = r_neg ? 16'(18'd0 - mag) : 16'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_start && o_ready) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (r_busy) begin
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && o_ready) begin
            r_m   <= i_m;
            r_len <= i_len;
            r_neg <= i_neg;
        end
        if (r_busy && r_cnt == 4'd0) begin
            r_rem <= num;
            r_dsh <= DW'(r_len) << 17;
            r_ovf <= num >= (DW'(r_len) << 18);
            r_q   <= 18'd0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dsh <= n_dsh;
            r_q   <= n_q;
        end
    end

endmodule

// ----- sv/stl_lane.sv -----
// ----------------------------------------------------------------------------
// Midpoint lane
// Sums one triangle edge, takes the vector length and normalizes the sum.
// ----------------------------------------------------------------------------
module stl_lane #(
    parameter int FRAC_BITS = stl_pkg::FRAC_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  stl_pkg::t_vec i_p,
    input  stl_pkg::t_vec i_q,
    input  logic          i_tag,
    output logic          o_valid,
    input  logic          i_take,
    output stl_pkg::t_vert o_vert,
    output stl_pkg::t_vec o_corner,
    output logic          o_tag
);

    localparam logic [3:0] LAST = 4'd11;

    logic          r_a_busy;
    logic [3:0]    r_a_cnt;
    logic [16:0]   r_m [3];
    logic [2:0]    r_neg;
    logic [33:0]   r_sq [3];
    stl_pkg::t_vec r_cor;
    logic          r_tag;
    logic [65:0]   r_rad;
    logic [34:0]   r_rem;
    logic [32:0]   r_root;
    logic          r_zero;
    logic          r_b_deg;
    stl_pkg::t_vec r_b_cor;
    logic          r_b_tag;

    logic signed [15:0] pc [3];
    logic signed [15:0] qc [3];
    logic signed [16:0] s [3];
    logic [16:0]   m [3];
    logic [33:0]   sq [3];
    logic [33:0]   len2;
    logic [34:0]   n_rem;
    logic [32:0]   n_root;
    logic          a_acc;
    logic          a_hand;
    logic [2:0]    div_ready;
    logic [2:0]    div_valid;
    logic signed [15:0] div_val [3];
    logic          b_free;

    assign pc[0] = i_p.x;
    assign pc[1] = i_p.y;
    assign pc[2] = i_p.z;
    assign qc[0] = i_q.x;
    assign qc[1] = i_q.y;
    assign qc[2] = i_q.z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i]  = 17'(pc[i]) + 17'(qc[i]);
            m[i]  = s[i][16] ? 17'(17'd0 - s[i]) : 17'(s[i]);
            sq[i] = 34'(m[i]) * 34'(m[i]);
        end
        len2 = r_sq[0] + r_sq[1] + r_sq[2];
    end

    always_comb begin
        logic [34:0] rem;
        logic [32:0] root;
        logic [65:0] rad;
        logic [34:0] trial;
        rem  = r_rem;
        root = r_root;
        rad  = r_rad;
        for (int j = 0; j < 3; j++) begin
            rem   = {rem[32:0], rad[65:64]};
            rad   = rad << 2;
            trial = {root[32:0], 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[31:0], 1'b1};
            end else begin
                root = {root[31:0], 1'b0};
            end
        end
        n_rem  = rem;
        n_root = root;
    end

    assign b_free  = &div_ready;
    assign a_hand  = r_a_busy && (r_a_cnt == LAST) && b_free;
    assign o_ready = !r_a_busy || a_hand;
    assign a_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_busy <= 1'b0;
            r_a_cnt  <= 4'd0;
        end else if (a_acc) begin
            r_a_busy <= 1'b1;
            r_a_cnt  <= 4'd0;
        end else if (a_hand) begin
            r_a_busy <= 1'b0;
        end else if (r_a_busy && r_a_cnt != LAST) begin
            r_a_cnt <= r_a_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_acc) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]   <= m[i];
                r_neg[i] <= s[i][16];
                r_sq[i]  <= sq[i];
            end
            r_cor <= i_p;
            r_tag <= i_tag;
        end
        if (r_a_busy && r_a_cnt == 4'd0) begin
            r_rad  <= {4'd0, len2, 28'd0};
            r_rem  <= 35'd0;
            r_root <= 33'd0;
            r_zero <= (len2 == 34'd0);
        end else if (r_a_busy && (r_a_cnt != LAST || a_hand)) begin
            r_rad  <= r_rad << 6;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
        if (a_hand) begin
            r_b_deg <= r_zero;
            r_b_cor <= r_cor;
            r_b_tag <= r_tag;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        stl_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (a_hand),
            .o_ready (div_ready[g]),
            .i_m     (r_m[g]),
            .i_len   (n_root[30:0]),
            .i_neg   (r_neg[g]),
            .o_valid (div_valid[g]),
            .i_take  (i_take),
            .o_val   (div_val[g])
        );
    end

    assign o_valid      = &div_valid;
    assign o_vert.deg   = r_b_deg;
    assign o_vert.pos.x = r_b_deg ? '0 : div_val[0];
    assign o_vert.pos.y = r_b_deg ? '0 : div_val[1];
    assign o_vert.pos.z = r_b_deg ? '0 : div_val[2];
    assign o_corner     = r_b_cor;
    assign o_tag        = r_b_tag;

endmodule

// ----- sv/stl_emit.sv -----
// ----------------------------------------------------------------------------
// Child triangle emitter
// Buffers the three corners and three midpoints and sends twelve vertices.
// ----------------------------------------------------------------------------
module stl_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_take,
    input  stl_pkg::t_vert i_vert [stl_pkg::NUM_VERTS],
    input  logic           i_eom,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [47:0]    o_m_tdata,
    output logic           o_m_tlast,
    output logic [1:0]     o_m_tuser
);

    localparam logic [3:0] LAST = 4'(stl_pkg::VERTS_PER_TRI - 1);

    logic           r_full;
    logic [3:0]     r_idx;
    stl_pkg::t_vert r_buf [stl_pkg::NUM_VERTS];
    logic           r_eom;
    stl_pkg::t_vert v;

    assign o_take = i_valid && (!r_full || (r_idx == LAST && i_m_tready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 4'd0;
        end else if (o_take) begin
            r_full <= 1'b1;
            r_idx  <= 4'd0;
        end else if (r_full && i_m_tready) begin
            if (r_idx == LAST) begin
                r_full <= 1'b0;
                r_idx  <= 4'd0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_buf <= i_vert;
            r_eom <= i_eom;
        end
    end

    assign v          = r_buf[stl_pkg::emit_sel(r_idx)];
    assign o_m_tvalid = r_full;
    assign o_m_tdata  = v.pos;
    assign o_m_tlast  = (r_idx == LAST);
    assign o_m_tuser  = {v.deg, r_eom && (r_idx == LAST)};

`ifndef ASSERT_OFF
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> r_idx == 4'd0)
        else $error("vertex index left nonzero while buffer empty");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata == 48'd0)
        else $error("degenerate vertex is not the zero vector");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tuser[0] |-> o_m_tlast)
        else $error("mesh done flag away from the last vertex");
`endif

endmodule

// ----- sv/sphere_triangle_subdivider.sv -----
// ----------------------------------------------------------------------------
// Sphere triangle subdivider
// Splits one unit-sphere triangle into four children as twelve vertices.
// ----------------------------------------------------------------------------
// Each request carries one triangle and yields twelve vertices, one per
// cycle while the output is not stalled. Three lanes each normalize one
// edge sum with a square root unit producing three result bits per cycle
// until it waits for free dividers, and the dividers and the vertex buffer
// work on earlier triangles while the square root unit runs.
module sphere_triangle_subdivider #(
    parameter int COORD_FRAC_BITS = stl_pkg::FRAC_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up.
    input  logic [143:0]  i_s_tdata,
    input  logic          i_s_tlast,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // out_x, out_y, out_z from the lowest bit up.
    output logic [47:0]   o_m_tdata,
    output logic          o_m_tlast,
    // mesh_done, degenerate from the lowest bit up.
    output logic [1:0]    o_m_tuser
);

    stl_pkg::t_vec  vin [3];
    logic [2:0]     lane_ready;
    logic [2:0]     lane_valid;
    logic [2:0]     lane_tag;
    logic           lane_go;
    logic           take;
    stl_pkg::t_vert mid [3];
    stl_pkg::t_vec  cor [3];
    stl_pkg::t_vert verts [stl_pkg::NUM_VERTS];

    assign vin[0]     = i_s_tdata[47:0];
    assign vin[1]     = i_s_tdata[95:48];
    assign vin[2]     = i_s_tdata[143:96];
    assign o_s_tready = &lane_ready;
    assign lane_go    = i_s_tvalid && o_s_tready;

    for (genvar g = 0; g < stl_pkg::NUM_LANES; g++) begin : g_lane
        stl_lane #(
            .FRAC_BITS (COORD_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (lane_go),
            .o_ready  (lane_ready[g]),
            .i_p      (vin[g]),
            .i_q      (vin[(g + 1) % 3]),
            .i_tag    (i_s_tlast),
            .o_valid  (lane_valid[g]),
            .i_take   (take),
            .o_vert   (mid[g]),
            .o_corner (cor[g]),
            .o_tag    (lane_tag[g])
        );
        assign verts[g]     = '{deg: 1'b0, pos: cor[g]};
        assign verts[g + 3] = mid[g];
    end

    stl_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (&lane_valid),
        .o_take     (take),
        .i_vert     (verts),
        .i_eom      (&lane_tag),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ----- tb/sphere_triangle_subdivider_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivider testbench
// Drives triangles with random gaps and holds the output back at random. Each
// request is predicted as twelve child vertices, and every emitted vertex is
// checked field by field against the oldest vertex still outstanding.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider_tb;

    localparam int FRAC = stl_pkg::FRAC_DEFAULT;

    typedef struct packed {
        logic       mesh_done;
        logic       deg;
        logic       last;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } t_child;

    class vertex_scoreboard;
        t_child pending[$];
        int     errors;
        int     checked;
        int     degens;

        function automatic longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic logic unit_midpoint(input logic signed [15:0] p[3],
                                               input logic signed [15:0] q[3],
                                               output logic [15:0] o[3]);
            longint signed   s[3];
            longint unsigned m[3];
            longint unsigned len2;
            longint unsigned len;
            longint unsigned mag;
            longint unsigned cap;
            len2 = 0;
            for (int i = 0; i < 3; i++) begin
                s[i] = longint'(p[i]) + longint'(q[i]);
                m[i] = (s[i] < 0) ? -s[i] : s[i];
                len2 += m[i] * m[i];
            end
            if (len2 == 0) begin
                for (int i = 0; i < 3; i++) o[i] = '0;
                return 1'b1;
            end
            len = root64(len2 << 28);
            for (int i = 0; i < 3; i++) begin
                mag = ((m[i] << (FRAC + 14)) + (len >> 1)) / len;
                cap = (s[i] < 0) ? 32768 : 32767;
                if (mag > cap) mag = cap;
                o[i] = (s[i] < 0) ? 16'(-mag) : 16'(mag);
            end
            return 1'b0;
        endfunction

        function void note_request(input logic [143:0] data, input logic eom);
            logic signed [15:0] c[3][3];
            logic [15:0] vtx[6][3];
            logic deg[6];
            logic [15:0] o[3];
            t_child r;
            logic [2:0] sel;
            for (int v = 0; v < 3; v++) begin
                for (int i = 0; i < 3; i++) begin
                    c[v][i] = data[(v*3+i)*16 +: 16];
                    vtx[v][i] = c[v][i];
                end
                deg[v] = 1'b0;
            end
            deg[stl_pkg::V_M12] = unit_midpoint(c[0], c[1], o);
            vtx[stl_pkg::V_M12] = o;
            deg[stl_pkg::V_M23] = unit_midpoint(c[1], c[2], o);
            vtx[stl_pkg::V_M23] = o;
            deg[stl_pkg::V_M31] = unit_midpoint(c[2], c[0], o);
            vtx[stl_pkg::V_M31] = o;
            for (int k = 0; k < stl_pkg::VERTS_PER_TRI; k++) begin
                case (k)
                    0, 4, 8:  sel = (k == 0) ? stl_pkg::V_A :
                                    (k == 4) ? stl_pkg::V_B : stl_pkg::V_C;
                    1, 3, 10: sel = stl_pkg::V_M12;
                    5, 7, 11: sel = stl_pkg::V_M23;
                    default:  sel = stl_pkg::V_M31;
                endcase
                r.x = vtx[sel][0];
                r.y = vtx[sel][1];
                r.z = vtx[sel][2];
                r.deg = deg[sel];
                r.last = (k == stl_pkg::VERTS_PER_TRI - 1);
                r.mesh_done = r.last & eom;
                if (deg[sel]) degens++;
                pending.push_back(r);
            end
        endfunction

        function void check_vertex(input t_child got);
            t_child want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected vertex %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("Vertex mismatch: x %h/%h y %h/%h z %h/%h",
                             want.x, got.x, want.y, got.y, want.z, got.z,
                             " last %b/%b done %b/%b deg %b/%b",
                             want.last, got.last, want.mesh_done, got.mesh_done,
                             want.deg, got.deg);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [143:0] i_s_tdata;
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;
    logic         o_m_tlast;
    logic [1:0]   o_m_tuser;

    vertex_scoreboard sb;
    int  sent;
    bit  hold_off;
    bit  stim_done;

    sphere_triangle_subdivider #(.COORD_FRAC_BITS(FRAC)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("sphere_triangle_subdivider test failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_triangle(input logic [143:0] data, input logic eom, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(data, eom);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [143:0] pack_tri(input int v[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'(v[i]);
        return d;
    endfunction

    initial begin
        int t[9];
        logic [143:0] d;
        sb = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        hold_off   = 1'b0;
        stim_done  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        t = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_triangle(pack_tri(t), 1'b0, 0);
        t = '{16384, 0, 0, -16384, 0, 0, 0, 0, 16384};
        send_triangle(pack_tri(t), 1'b1, 0);
        t = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_triangle(pack_tri(t), 1'b0, 0);
        t = '{-16384, -16384, -16384, -16384, -16384, -16384, 16384, 16384, 16384};
        send_triangle(pack_tri(t), 1'b1, 0);
        t = '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768};
        send_triangle(pack_tri(t), 1'b0, 0);
        t = '{-32768, 0, 1, -32768, 0, -1, 1, 1, 1};
        send_triangle(pack_tri(t), 1'b1, 0);
        t = '{1, 0, 0, 0, 1, 0, -1, 0, 0};
        send_triangle(pack_tri(t), 1'b0, 0);
        send_triangle({144{1'b1}}, 1'b1, 0);
        send_triangle({72{2'b10}}, 1'b0, 0);
        send_triangle({72{2'b01}}, 1'b1, 0);

        // Hold the output back long enough that the block must stall its input.
        hold_off = 1'b1;
        for (int n = 0; n < 100; n++) begin
            for (int i = 0; i < 9; i++) d[i*16 +: 16] = rand_coord();
            if ($urandom_range(0, 9) == 0) begin
                d[63:48] = -d[15:0];
                d[79:64] = -d[31:16];
                d[95:80] = -d[47:32];
            end
            send_triangle(d, 1'($urandom_range(0, 7) == 0), n > 5);
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int stall_cycles;
        bit stalled;
        i_m_tready = 1'b0;
        stalled    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off && !stalled) begin
                stalled = 1'b1;
                i_m_tready <= 1'b0;
                stall_cycles = 0;
                while (stall_cycles < 400) begin
                    @(negedge i_clk);
                    stall_cycles++;
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 9) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_vertex({o_m_tuser[0], o_m_tuser[1], o_m_tlast,
                             o_m_tdata[47:32], o_m_tdata[31:16], o_m_tdata[15:0]});
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d triangles and checked %0d vertices, %0d of them degenerate.",
                 sent, sb.checked, sb.degens);
        $display("Runs included a long output stall and random gaps on both sides.");
        if (sb.errors == 0) begin
            $display("sphere_triangle_subdivider test passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("sphere_triangle_subdivider test failed");
        end
        $finish;
    end

endmodule

// ----- sphere_triangle_subdivider.f -----
sv/stl_pkg.sv
sv/stl_div.sv
sv/stl_lane.sv
sv/stl_emit.sv
sv/sphere_triangle_subdivider.sv
tb/sphere_triangle_subdivider_tb.sv
